@@ rtl/prr_pkg.sv @@
// ============================================================================
// prr_pkg
// Shared types, constants and helpers of the pulse run resampler.
// ============================================================================
`default_nettype none

package prr_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int COUNT_BITS    = 32;

    localparam int SAMPLES_W = 32;
    localparam int STEP_W    = 32;
    localparam int RUN_W     = 48;

    localparam int N_W     = (COUNT_BITS < SAMPLES_W) ? COUNT_BITS : SAMPLES_W;
    localparam int NFX_W   = N_W + FRACTION_BITS;
    localparam int COMP_W  = (NFX_W > STEP_W) ? NFX_W : STEP_W;
    localparam int CNT_W   = NFX_W + 1;
    localparam int WIDE_W  = (CNT_W > RUN_W) ? CNT_W : RUN_W;
    localparam int DIV_CNT_W = $clog2(NFX_W + 1);

    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRACTION_BITS;
    localparam logic [RUN_W-1:0]  RUN_MAX  = {RUN_W{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SAMPLES_W-1:0] pulse_samples;
        logic                 pulse_level;
    } pulse_t;

    typedef struct packed {
        logic             run_level;
        logic [RUN_W-1:0] run_length;
        logic             run_last;
    } run_t;

    typedef struct packed {
        logic [N_W-1:0] samples;
        logic           level;
    } qitem_t;

    function automatic logic [RUN_W-1:0] sat_run(input logic [CNT_W-1:0] n);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(n);
        if (wide > WIDE_W'(RUN_MAX))
            return RUN_MAX;
        return wide[RUN_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/prr_front.sv @@
// ============================================================================
// prr_front
// Input side: accept pulse items, trim the count and hold them in a short
// queue for the back end.
// ============================================================================
`default_nettype none

module prr_front
    import prr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   pulse_valid,
    output logic        pulse_stall,
    input  wire pulse_t pulse_item,
    output logic        q_valid,
    output qitem_t      q_item,
    input  wire logic   q_pop
);

    qitem_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push, pop;

    assign pulse_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid     = (count_reg != '0);
    assign q_item      = entry_reg[rd_ptr_reg];
    assign push        = pulse_valid && !pulse_stall;
    assign pop         = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].samples <= pulse_item.pulse_samples[N_W-1:0];
            entry_reg[wr_ptr_reg].level   <= pulse_item.pulse_level;
        end
    end

endmodule

`default_nettype wire

@@ rtl/prr_div.sv @@
// ============================================================================
// prr_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module prr_div
    import prr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NFX_W-1:0]  dividend,
    input  wire logic [STEP_W-1:0] divisor,
    output logic                   done,
    output logic [NFX_W-1:0]       quotient,
    output logic [STEP_W-1:0]      remainder
);

    logic [NFX_W-1:0]     quo_reg, quo_next;
    logic [STEP_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [STEP_W:0]      trial;

    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign trial     = {rem_reg, quo_reg[NFX_W-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(NFX_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = STEP_W'(trial - {1'b0, dvs_reg});
                    quo_next = {quo_reg[NFX_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[STEP_W-1:0];
                    quo_next = {quo_reg[NFX_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

endmodule

`default_nettype wire

@@ rtl/prr_back.sv @@
// ============================================================================
// prr_back
// Execution side: keep scan distance and level, split each scanned pulse into
// runs and drive the output register.
// ============================================================================
`default_nettype none

module prr_back
    import prr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [STEP_W-1:0] cfg_data,
    input  wire logic              q_valid,
    input  wire qitem_t            q_item,
    output logic                   q_pop,
    output logic                   run_valid,
    input  wire logic              run_stall,
    output run_t                   run_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RUN1 = 2'd2;
    localparam logic [1:0] ST_RUN2 = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] dist_reg, dist_next;
    logic              prev_reg, prev_next;
    logic              level_reg, first_reg, split_reg;
    logic              run_valid_reg, run_valid_next;
    run_t              run_reg, run_next;

    logic [STEP_W-1:0] s_eff;
    logic [NFX_W-1:0]  nfx;
    logic              no_scan, first_new, load_ok;
    logic              div_start, div_done;
    logic [NFX_W-1:0]  div_quo;
    logic [STEP_W-1:0] div_rem;

    assign s_eff     = (step_reg == '0) ? STEP_ONE : step_reg;
    assign nfx       = {q_item.samples, {FRACTION_BITS{1'b0}}};
    assign no_scan   = COMP_W'(nfx) < COMP_W'(dist_reg);
    assign first_new = (prev_reg == q_item.level) || ({dist_reg, 1'b0} >= {1'b0, s_eff});
    assign load_ok   = !run_valid_reg || !run_stall;
    assign run_valid = run_valid_reg;
    assign run_item  = run_reg;

    prr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (NFX_W'(COMP_W'(nfx) - COMP_W'(dist_reg))),
        .divisor   (s_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        dist_next      = dist_reg;
        prev_next      = prev_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        run_next       = run_reg;
        run_valid_next = run_valid_reg && run_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    prev_next = q_item.level;
                    if (no_scan)
                    begin
                        dist_next = STEP_W'(COMP_W'(dist_reg) - COMP_W'(nfx));
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    dist_next  = s_eff - div_rem;
                    state_next = ST_RUN1;
                end
            end
            ST_RUN1:
            begin
                if (load_ok)
                begin
                    run_valid_next = 1'b1;
                    if (split_reg)
                    begin
                        run_next.run_level  = first_reg;
                        run_next.run_length = RUN_W'(1);
                        run_next.run_last   = (div_quo == '0);
                        state_next = (div_quo == '0) ? ST_IDLE : ST_RUN2;
                    end
                    else
                    begin
                        run_next.run_level  = level_reg;
                        run_next.run_length = sat_run(CNT_W'(div_quo) + CNT_W'(1));
                        run_next.run_last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RUN2:
            begin
                if (load_ok)
                begin
                    run_valid_next      = 1'b1;
                    run_next.run_level  = level_reg;
                    run_next.run_length = sat_run(CNT_W'(div_quo));
                    run_next.run_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_ONE;
            dist_reg      <= STEP_ONE;
            prev_reg      <= 1'b0;
            run_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dist_reg      <= dist_next;
            prev_reg      <= prev_next;
            run_valid_reg <= run_valid_next;
            if (cfg_valid)
                step_reg <= cfg_data;
        end
    end

    // hold item attributes for the run phase
    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        if (div_start)
        begin
            level_reg <= q_item.level;
            first_reg <= prev_reg;
            split_reg <= !first_new;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pulse_run_resampler_core.sv @@
// ============================================================================
// pulse_run_resampler_core
// Resample run-length pulses to a new rate, zero, one or two runs per pulse.
// ============================================================================
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  pulse    | pulse_valid/stall   | pulse_item: pulse_samples, pulse_level
//  run      | run_valid/stall     | run_item: run_level, run_length, run_last
//  cfg      | cfg_valid/ready     | cfg_data: step_ratio (UQ16.16)
//
//  A pulse with no scan only updates scan distance and previous level in the back end.
//  Other pulses go through the restoring divider on NFX_W bits (48 at 16 fraction
//  bits and 32 count bits), then give one or two runs.
//  A two-entry queue holds pulses while the back end is busy.
//  Reset: step and scan distance 1.0, previous level 0, queue empty.
//  Output stall holds the run register; input stall rises when the queue fills.
// ============================================================================
`default_nettype none

module pulse_run_resampler_core
    import prr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pulse_valid,
    output logic                   pulse_stall,
    input  wire pulse_t            pulse_item,
    output logic                   run_valid,
    input  wire logic              run_stall,
    output run_t                   run_item,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [STEP_W-1:0] cfg_data
);

    logic   q_valid;
    logic   q_pop;
    qitem_t q_item;

    assign cfg_ready = 1'b1;

    prr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_valid (pulse_valid),
        .pulse_stall (pulse_stall),
        .pulse_item  (pulse_item),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    prr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .run_valid (run_valid),
        .run_stall (run_stall),
        .run_item  (run_item)
    );

endmodule

`default_nettype wire

@@ rtl/prr_checker.sv @@
// ============================================================================
// prr_checker
// Port-level checks of the pulse run resampler, bound to the top level.
// ============================================================================
`default_nettype none

module prr_checker
    import prr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              pulse_valid,
    input wire logic              pulse_stall,
    input wire pulse_t            pulse_item,
    input wire logic              run_valid,
    input wire logic              run_stall,
    input wire run_t              run_item,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic [STEP_W-1:0] cfg_data
);

    a_run_hold: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_stall |=> run_valid && $stable(run_item))
        else $error("run item changed while stalled");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> run_item.run_length != '0)
        else $error("empty run emitted");

    a_split_first: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !run_item.run_last |-> run_item.run_length == RUN_W'(1))
        else $error("leading run of a split pulse longer than one scan");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !run_valid)
        else $error("run valid during reset");

endmodule

bind pulse_run_resampler_core prr_checker u_prr_checker (.*);

`default_nettype wire

@@ tb/pulse_run_resampler_core_test.sv @@
// ============================================================================
// pulse_run_resampler_core_test
// Self-checking bench for the pulse run resampler. A short table of directed
// pulses and step writes covers the edges of the half-step rule and the field
// extremes. Random pulses follow over a series of step settings. Every run
// item is compared with the runs predicted for each accepted pulse.
// ============================================================================

module pulse_run_resampler_core_test;
    import prr_pkg::*;

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int SETTLE_CYCLES   = 80;
    localparam int LONG_HOLD       = 400;
    localparam int MAX_WAIT        = 13;

    typedef enum logic {ROW_PULSE, ROW_STEP} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [SAMPLES_W-1:0] value;
        logic                 level;
        logic                 fixed;
        logic                 emits;
        run_t                 want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              pulse_valid;
    logic              pulse_stall;
    pulse_t            pulse_item;
    logic              run_valid;
    logic              run_stall;
    run_t              run_item;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [STEP_W-1:0] cfg_data;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] scan_dist;
    logic              prev_level;
    run_t              expected_runs[$];
    int                err_count = 0;
    bit                hold_req = 1'b0;
    bit                tx_quiet = 1'b0;

    stim_row_t stim_table [22] = '{
        '{ROW_PULSE, 32'd0,          1'b1, 1'b1, 1'b0, '0},
        '{ROW_PULSE, 32'd1,          1'b1, 1'b1, 1'b1, '{1'b1, 48'd1, 1'b1}},
        '{ROW_PULSE, 32'd5,          1'b0, 1'b1, 1'b1, '{1'b0, 48'd5, 1'b1}},
        '{ROW_PULSE, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, '{1'b1, 48'hFFFF_FFFF, 1'b1}},
        '{ROW_STEP,  32'h0002_0000,  1'b0, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'd1,          1'b0, 1'b1, 1'b1, '{1'b0, 48'd1, 1'b1}},
        '{ROW_STEP,  32'h0002_0002,  1'b0, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'd1,          1'b0, 1'b1, 1'b0, '0},
        '{ROW_PULSE, 32'd1,          1'b1, 1'b1, 1'b1, '{1'b0, 48'd1, 1'b1}},
        '{ROW_PULSE, 32'd7,          1'b0, 1'b0, 1'b0, '0},
        '{ROW_STEP,  32'h0000_0001,  1'b0, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'd3,          1'b0, 1'b0, 1'b0, '0},
        '{ROW_STEP,  32'h0000_0000,  1'b0, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'd3,          1'b1, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'd1,          1'b0, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'd0,          1'b1, 1'b0, 1'b0, '0},
        '{ROW_STEP,  32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'h0001_0000,  1'b1, 1'b0, 1'b0, '0},
        '{ROW_PULSE, 32'd0,          1'b0, 1'b0, 1'b0, '0},
        '{ROW_STEP,  32'h0001_0000,  1'b0, 1'b0, 1'b0, '0}
    };

    pulse_run_resampler_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_valid (pulse_valid),
        .pulse_stall (pulse_stall),
        .pulse_item  (pulse_item),
        .run_valid   (run_valid),
        .run_stall   (run_stall),
        .run_item    (run_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [RUN_W-1:0] clamp_run(input logic [63:0] n);
        return (n > 64'(RUN_MAX)) ? RUN_MAX : n[RUN_W-1:0];
    endfunction

    function automatic int resample_pulse(input pulse_t p, output run_t r0, output run_t r1);
        logic [63:0] s;
        logic [63:0] d;
        logic [63:0] nfx;
        logic [63:0] rem;
        logic [63:0] count;
        logic        first;
        s   = (step_reg == '0) ? 64'(STEP_ONE) : 64'(step_reg);
        d   = 64'(scan_dist);
        nfx = 64'(p.pulse_samples[N_W-1:0]) << FRACTION_BITS;
        r0  = '0;
        r1  = '0;
        if (nfx < d)
        begin
            scan_dist  = STEP_W'(d - nfx);
            prev_level = p.pulse_level;
            return 0;
        end
        rem       = nfx - d;
        count     = 64'd1 + rem / s;
        scan_dist = STEP_W'(s - rem % s);
        first     = (prev_level == p.pulse_level || 2 * d >= s) ? p.pulse_level : prev_level;
        prev_level = p.pulse_level;
        if (first == p.pulse_level)
        begin
            r0 = '{p.pulse_level, clamp_run(count), 1'b1};
            return 1;
        end
        r0 = '{first, RUN_W'(1), count == 64'd1};
        if (count == 64'd1)
            return 1;
        r1 = '{p.pulse_level, clamp_run(count - 64'd1), 1'b1};
        return 2;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic send_pulse(input pulse_t p, input logic fixed, input logic emits,
                              input run_t want);
        int   gap;
        int   k;
        run_t r0;
        run_t r1;
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        repeat (gap)
        begin
            @(negedge clk);
            pulse_valid <= 1'b0;
        end
        @(negedge clk);
        pulse_valid <= 1'b1;
        pulse_item  <= p;
        do @(posedge clk); while (pulse_stall);
        k = resample_pulse(p, r0, r1);
        if (fixed)
        begin
            if (emits)
                expected_runs.push_back(want);
        end
        else
        begin
            if (k > 0)
                expected_runs.push_back(r0);
            if (k > 1)
                expected_runs.push_back(r1);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        pulse_valid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        step_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #10_000_000;
        $display("** pulse_run_resampler_core: FAILED **");
        $finish;
    end

    // receive side: check each run item, then stall for a drawn number of cycles
    initial
    begin
        int   wait_left;
        int   hold_left;
        bit   rx_quiet;
        run_t want;
        run_stall = 1'b0;
        wait_left = 0;
        hold_left = 0;
        rx_quiet  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && run_valid && !run_stall)
            begin
                if (expected_runs.size() == 0)
                begin
                    $display("%0t: unexpected run, expected none, got level %0d length %0h last %0d",
                             $time, run_item.run_level, run_item.run_length,
                             run_item.run_last);
                    err_count++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    check_field("run_level", want.run_level, run_item.run_level);
                    check_field("run_length", want.run_length, run_item.run_length);
                    check_field("run_last", want.run_last, run_item.run_last);
                end
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                wait_left = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                run_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                run_stall <= 1'b1;
            end
            else
                run_stall <= 1'b0;
        end
    end

    initial
    begin
        pulse_t            p;
        logic              lvl;
        logic [STEP_W-1:0] step_v;
        logic [STEP_W-1:0] eff;
        logic [31:0]       span;
        int                sel;
        rst_n       = 1'b0;
        pulse_valid = 1'b0;
        pulse_item  = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        step_reg    = STEP_ONE;
        scan_dist   = STEP_ONE;
        prev_level  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_STEP)
                write_step(stim_table[i].value);
            else
            begin
                p.pulse_samples = stim_table[i].value;
                p.pulse_level   = stim_table[i].level;
                send_pulse(p, stim_table[i].fixed, stim_table[i].emits, stim_table[i].want);
            end
        end

        lvl = 1'b0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       step_v = STEP_ONE;
                1:       step_v = 32'h0000_8000;
                2:       step_v = 32'h0001_8000;
                3:       step_v = $urandom;
                4:       step_v = 32'h0000_0010;
                5:       step_v = $urandom_range(1, 32'h0000_FFFF);
                6:       step_v = '1;
                7:       step_v = '0;
                default: step_v = $urandom_range(32'h0000_4000, 32'h0008_0000);
            endcase
            write_step(step_v);
            eff  = (step_reg == '0) ? STEP_ONE : step_reg;
            span = (eff >> FRACTION_BITS) * 3 + 4;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (ph == 2 && i == 60)
                    hold_req = 1'b1;
                if (ph == 5 && i == 100)
                    drain();
                lvl = ($urandom_range(0, 4) != 0) ? !lvl : 1'($urandom_range(0, 1));
                sel = $urandom_range(0, 99);
                if (sel < 5)
                    p.pulse_samples = '0;
                else if (sel < 10)
                    p.pulse_samples = $urandom;
                else
                    p.pulse_samples = $urandom_range(0, span);
                p.pulse_level = lvl;
                send_pulse(p, 1'b0, 1'b0, '0);
            end
        end

        drain();
        if (err_count == 0)
            $display("** pulse_run_resampler_core: PASSED **");
        else
            $display("** pulse_run_resampler_core: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/prr_pkg.sv
rtl/prr_front.sv
rtl/prr_div.sv
rtl/prr_back.sv
rtl/pulse_run_resampler_core.sv
rtl/prr_checker.sv
tb/pulse_run_resampler_core_test.sv
